@@ design/mbrc_pkg.sv @@
// ---------------------------------------------------------------------------
// mbrc_pkg
// Shared types and constants for the Modbus RTU read-response checker.
// ---------------------------------------------------------------------------
`default_nettype none

package mbrc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_HEADER = 2'd1,
        STATUS_COUNT  = 2'd2,
        STATUS_CRC    = 2'd3
    } status_t;

    // Input word opcodes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE = 1'd1;

    localparam logic [7:0] SLAVE_ADDRESS_RST = 8'h01;
    localparam logic [7:0] FUNCTION_CODE_RST = 8'h03;

    // Byte positions within a response frame
    localparam logic [2:0] POS_ADDR     = 3'd0;
    localparam logic [2:0] POS_FUNC     = 3'd1;
    localparam logic [2:0] POS_COUNT    = 3'd2;
    localparam logic [2:0] POS_VALUE_HI = 3'd3;
    localparam logic [2:0] POS_VALUE_LO = 3'd4;
    localparam logic [2:0] POS_CRC_LO   = 3'd5;
    localparam logic [2:0] POS_CRC_HI   = 3'd6;
    localparam logic [2:0] FRAME_LEN    = 3'd7;

    localparam logic [7:0]  EXPECTED_COUNT = 8'd2;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

endpackage : mbrc_pkg

`default_nettype wire

@@ design/mbrc_if.sv @@
// ---------------------------------------------------------------------------
// mbrc_byte_if / mbrc_result_if
// Valid/ready channels carrying received bytes in and check results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface mbrc_byte_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface : mbrc_byte_if

interface mbrc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] register_value;

    modport source (output valid, output status, output register_value, input ready);
    modport sink   (input valid, input status, input register_value, output ready);
endinterface : mbrc_result_if

`default_nettype wire

@@ design/mbrc_crc_byte.sv @@
// ---------------------------------------------------------------------------
// mbrc_crc_byte
// One-byte update of the reflected Modbus CRC16, unrolled into XOR logic.
// ---------------------------------------------------------------------------
`default_nettype none

module mbrc_crc_byte (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_out
);

    logic [15:0] acc;

    // shift out the eight data bits, LSB first
    always_comb
    begin
        acc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ mbrc_pkg::CRC_POLY;
            else
                acc = acc >> 1;
        end
        crc_out = acc;
    end

endmodule : mbrc_crc_byte

`default_nettype wire

@@ design/modbus_read_response_checker.sv @@
// ---------------------------------------------------------------------------
// modbus_read_response_checker
// Checks a 7-byte Modbus RTU single-register read response, one byte a word.
// ---------------------------------------------------------------------------
// Throughput: one byte word per cycle; the CRC update is one unrolled byte step.
// The result word is registered and valid in the cycle after the seventh byte is taken.
// A result waiting at the output stalls the input only on the seventh byte.
// Reset: empty frame, CRC 0xFFFF, slave address 1, function code 3, no result.
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_read_response_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mbrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data,
    mbrc_byte_if.sink                             bytes,
    mbrc_result_if.source                         result
);

    logic [7:0]        slave_address_reg;
    logic [7:0]        function_code_reg;

    logic [2:0]        byte_count_reg,    byte_count_next;
    logic [15:0]       crc_reg,           crc_next;
    mbrc_pkg::status_t header_status_reg, header_status_next;
    logic [15:0]       value_hold_reg,    value_hold_next;
    logic [7:0]        crc_low_reg,       crc_low_next;

    logic              out_valid_reg,     out_valid_next;
    mbrc_pkg::status_t status_reg,        status_next;
    logic [15:0]       value_reg;

    logic [15:0]       crc_step;
    logic              accept;
    logic              result_load;

    // ---- configuration -----------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= mbrc_pkg::SLAVE_ADDRESS_RST;
            function_code_reg <= mbrc_pkg::FUNCTION_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrc_pkg::REG_SLAVE_ADDRESS: slave_address_reg <= cfg_data;
                mbrc_pkg::REG_FUNCTION_CODE: function_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- byte handling -----------------------------------------------------
    mbrc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (bytes.rx_byte),
        .crc_out (crc_step)
    );

    // hold the last byte only while an untaken result sits in the output
    assign bytes.ready = !out_valid_reg || result.ready ||
                         (byte_count_reg != mbrc_pkg::POS_CRC_HI);
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        crc_next           = crc_reg;
        header_status_next = header_status_reg;
        value_hold_next    = value_hold_reg;
        crc_low_next       = crc_low_reg;
        status_next        = status_reg;
        result_load        = 1'b0;

        if (accept)
        begin
            if (bytes.opcode == mbrc_pkg::OP_CLEAR)
            begin
                byte_count_next    = '0;
                crc_next           = mbrc_pkg::CRC_INIT;
                header_status_next = mbrc_pkg::STATUS_OK;
                value_hold_next    = '0;
                crc_low_next       = '0;
            end
            else if (byte_count_reg != mbrc_pkg::FRAME_LEN)
            begin
                byte_count_next = byte_count_reg + 3'd1;
                case (byte_count_reg)
                    mbrc_pkg::POS_ADDR:
                    begin
                        if (bytes.rx_byte != slave_address_reg)
                            header_status_next = mbrc_pkg::STATUS_HEADER;
                        crc_next = crc_step;
                    end
                    mbrc_pkg::POS_FUNC:
                    begin
                        if (bytes.rx_byte != function_code_reg &&
                            header_status_reg == mbrc_pkg::STATUS_OK)
                            header_status_next = mbrc_pkg::STATUS_HEADER;
                        crc_next = crc_step;
                    end
                    mbrc_pkg::POS_COUNT:
                    begin
                        if (bytes.rx_byte != mbrc_pkg::EXPECTED_COUNT &&
                            header_status_reg == mbrc_pkg::STATUS_OK)
                            header_status_next = mbrc_pkg::STATUS_COUNT;
                        crc_next = crc_step;
                    end
                    mbrc_pkg::POS_VALUE_HI:
                    begin
                        value_hold_next = {bytes.rx_byte, value_hold_reg[7:0]};
                        crc_next        = crc_step;
                    end
                    mbrc_pkg::POS_VALUE_LO:
                    begin
                        value_hold_next = {value_hold_reg[15:8], bytes.rx_byte};
                        crc_next        = crc_step;
                    end
                    mbrc_pkg::POS_CRC_LO:
                        crc_low_next = bytes.rx_byte;
                    default:
                    begin
                        // last byte: received CRC high, close the frame
                        result_load = 1'b1;
                        if (header_status_reg != mbrc_pkg::STATUS_OK)
                            status_next = header_status_reg;
                        else if ({bytes.rx_byte, crc_low_reg} != crc_reg)
                            status_next = mbrc_pkg::STATUS_CRC;
                        else
                            status_next = mbrc_pkg::STATUS_OK;
                    end
                endcase
            end
        end

        out_valid_next = result_load || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            crc_reg           <= mbrc_pkg::CRC_INIT;
            header_status_reg <= mbrc_pkg::STATUS_OK;
            value_hold_reg    <= '0;
            crc_low_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            crc_reg           <= crc_next;
            header_status_reg <= header_status_next;
            value_hold_reg    <= value_hold_next;
            crc_low_reg       <= crc_low_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (result_load)
            value_reg <= value_hold_reg;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.register_value = value_reg;

    // ---- assertions --------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= mbrc_pkg::FRAME_LEN)
        else $error("byte count beyond frame length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready &&
         byte_count_reg == mbrc_pkg::POS_CRC_HI) |-> !bytes.ready)
        else $error("last byte accepted while result still pending");

    a_frame_closed: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (byte_count_reg == mbrc_pkg::FRAME_LEN) && result.valid)
        else $error("frame not closed after result");

    a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && header_status_reg != mbrc_pkg::STATUS_OK)
        |=> result.status == $past(header_status_reg))
        else $error("header error not reported first");

endmodule : modbus_read_response_checker

`default_nettype wire
